>>> rtl/dsrc_pkg.sv
// shared types and constants for the display state residency counter
// no dependencies; imported by display_state_residency_counter
package dsrc_pkg;

  // default storage widths for time sums and entry counts
  localparam int DEF_TIME_BITS  = 48;
  localparam int DEF_COUNT_BITS = 32;

  // port field widths
  localparam int NOW_W   = 48;
  localparam int CLK_W   = 36;
  localparam int BLANK_W = 8;
  localparam int CNT_W   = 32;
  localparam int IDX_W   = 2;

  // number of tracked power states
  localparam int PWR_STATE_CNT = 3;

  // power state codes
  localparam logic [IDX_W-1:0] PS_OFF  = 2'd0;
  localparam logic [IDX_W-1:0] PS_60HZ = 2'd1;
  localparam logic [IDX_W-1:0] PS_90HZ = 2'd2;
  localparam logic [IDX_W-1:0] PS_LAST = IDX_W'(PWR_STATE_CNT - 1);

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_SOURCE_PRESENT = 2'd0;
  localparam logic [IDX_W-1:0] CFG_CLOCK_THRESH   = 2'd1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_QRD,
    ST_QEND
  } seq_state_t;

endpackage

>>> rtl/display_state_residency_counter.sv
// display power state residency counter, top level
// holds per-state totals, entry counts and entry times in two small memories
// depends on dsrc_pkg
//
// usage:
//   input: an item is transferred when start is high and busy is low.
//   in_mode 0 is a sample (backlight blank value, link clock, time),
//   in_mode 1 is a query.
//   a sample gives no result; when the state changes it reads the old and
//   new state entries, then writes them back in ST_UPD while busy is high.
//   a query gives three records (off, 60 Hz, 90 Hz) on consecutive cycles,
//   each marked by out_valid for one cycle; each state's entries are read
//   in ST_QRD, one memory read per state, then pass the read data register
//   and the output registers; busy stays high through ST_QRD and ST_QEND.
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, ready
//   always; to be written only while busy is low, which the block does not check.
//   reset (synchronous, rst_n low) clears all totals, counts and entry
//   times through per-entry valid bits, sets source_present to 1 and the
//   clock threshold to 0; no clearing pass is needed.
//   the receiver cannot stall: records are presented once and not held.
module display_state_residency_counter
  import dsrc_pkg::*;
#(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic [NOW_W-1:0]   in_now_ms,
  input  logic               in_blank_ok,
  input  logic [BLANK_W-1:0] in_blank_value,
  input  logic               in_clock_ok,
  input  logic [CLK_W-1:0]   in_clock_hz,
  // result channel
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_state_id,
  output logic [NOW_W-1:0]   out_total_time_ms,
  output logic [CNT_W-1:0]   out_entry_count,
  output logic [NOW_W-1:0]   out_last_entry_ms,
  output logic               out_report_ok,
  output logic               out_is_last,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CLK_W-1:0]   cfg_data
);

  localparam int E_W = COUNT_BITS + TIME_BITS;

  // sequencer and configuration
  seq_state_t              state_r, state_nxt;
  logic                    src_r;
  logic [CLK_W-1:0]        thr_r;

  // sample tracking
  logic [BLANK_W-1:0]      prev_blank_r;
  logic                    prev_known_r;
  logic [IDX_W-1:0]        cur_r;
  logic                    cur_known_r;

  // latched item
  logic [TIME_BITS-1:0]    now_r;
  logic [IDX_W-1:0]        nxt_r;
  logic [IDX_W-1:0]        old_r;
  logic                    had_r;

  // query sequencing
  logic [IDX_W-1:0]        q_idx_r;
  logic                    p_vld_r;
  logic [IDX_W-1:0]        p_idx_r;

  // memories: totals, and {entry count, entry time}
  logic [TIME_BITS-1:0]    t_mem [PWR_STATE_CNT];
  logic [E_W-1:0]          e_mem [PWR_STATE_CNT];
  logic [PWR_STATE_CNT-1:0] t_vld_r;
  logic [PWR_STATE_CNT-1:0] e_vld_r;
  logic [TIME_BITS-1:0]    rd_t_r;
  logic [E_W-1:0]          rd_e0_r;
  logic [E_W-1:0]          rd_e1_r;
  logic                    rd_t_vld_r;
  logic                    rd_e0_vld_r;
  logic                    rd_e1_vld_r;

  // output registers
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_state_id_r;
  logic [NOW_W-1:0]        out_total_r;
  logic [CNT_W-1:0]        out_count_r;
  logic [NOW_W-1:0]        out_last_r;
  logic                    out_ok_r;
  logic                    out_is_last_r;

  // combinational
  logic                    accept;
  logic                    blank_new;
  logic                    samp_take;
  logic                    samp_chg;
  logic [IDX_W-1:0]        cls;
  logic [IDX_W-1:0]        rd_a;
  logic [TIME_BITS-1:0]    t_eff;
  logic [COUNT_BITS-1:0]   e0_cnt;
  logic [TIME_BITS-1:0]    e0_time;
  logic [COUNT_BITS-1:0]   e1_cnt;
  logic [TIME_BITS-1:0]    elapsed;
  logic                    live;
  logic [TIME_BITS-1:0]    q_total;
  logic                    t_we;
  logic                    e_we;
  logic [TIME_BITS-1:0]    t_wdata;
  logic [E_W-1:0]          e_wdata;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && (state_r == ST_IDLE);

  // sample classification
  always_comb begin
    blank_new = !prev_known_r || (in_blank_value != prev_blank_r);
    samp_take = accept && !in_mode && src_r && in_blank_ok && blank_new;
    if (in_blank_value != '0) begin
      cls = PS_OFF;
    end else if (in_clock_ok && (in_clock_hz > thr_r)) begin
      cls = PS_90HZ;
    end else begin
      cls = PS_60HZ;
    end
    samp_chg = samp_take && (!cur_known_r || (cls != cur_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_mode) begin
          state_nxt = ST_QRD;
        end else if (samp_chg) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:  state_nxt = ST_IDLE;
      ST_QRD: begin
        if (q_idx_r == PS_LAST) begin
          state_nxt = ST_QEND;
        end
      end
      ST_QEND: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // read data with unwritten entries reading as zero
  always_comb begin
    rd_a    = (state_r == ST_QRD) ? q_idx_r : cur_r;
    t_eff   = rd_t_vld_r ? rd_t_r : '0;
    e0_cnt  = rd_e0_vld_r ? rd_e0_r[E_W-1:TIME_BITS] : '0;
    e0_time = rd_e0_vld_r ? rd_e0_r[TIME_BITS-1:0] : '0;
    e1_cnt  = rd_e1_vld_r ? rd_e1_r[E_W-1:TIME_BITS] : '0;
    elapsed = now_r - e0_time;
    live    = cur_known_r && (cur_r == p_idx_r);
    q_total = live ? (t_eff + elapsed) : t_eff;
  end

  // write back on a state change
  always_comb begin
    t_we    = (state_r == ST_UPD) && had_r;
    e_we    = (state_r == ST_UPD);
    t_wdata = t_eff + elapsed;
    e_wdata = {e1_cnt + COUNT_BITS'(1), now_r};
  end

  // memories
  always_ff @(posedge clk) begin
    if (t_we) begin
      t_mem[old_r] <= t_wdata;
    end
    if (e_we) begin
      e_mem[nxt_r] <= e_wdata;
    end
    rd_t_r  <= t_mem[rd_a];
    rd_e0_r <= e_mem[rd_a];
    rd_e1_r <= e_mem[cls];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      src_r        <= 1'b1;
      thr_r        <= '0;
      prev_blank_r <= '0;
      prev_known_r <= 1'b0;
      cur_r        <= PS_OFF;
      cur_known_r  <= 1'b0;
      t_vld_r      <= '0;
      e_vld_r      <= '0;
      q_idx_r      <= '0;
      p_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration transfer
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SOURCE_PRESENT: src_r <= cfg_data[0];
          CFG_CLOCK_THRESH:   thr_r <= cfg_data;
          default:            ;
        endcase
      end

      // remember last blank value
      if (samp_take) begin
        prev_blank_r <= in_blank_value;
        prev_known_r <= 1'b1;
      end

      // commit state change
      if (state_r == ST_UPD) begin
        cur_r          <= nxt_r;
        cur_known_r    <= 1'b1;
        e_vld_r[nxt_r] <= 1'b1;
        if (had_r) begin
          t_vld_r[old_r] <= 1'b1;
        end
      end

      // query read index
      if (accept) begin
        q_idx_r <= '0;
      end else if (state_r == ST_QRD) begin
        q_idx_r <= q_idx_r + IDX_W'(1);
      end

      p_vld_r     <= (state_r == ST_QRD);
      out_valid_r <= p_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_t_vld_r  <= t_vld_r[rd_a];
    rd_e0_vld_r <= e_vld_r[rd_a];
    rd_e1_vld_r <= e_vld_r[cls];
    p_idx_r     <= q_idx_r;
    if (accept) begin
      now_r <= TIME_BITS'(in_now_ms);
      nxt_r <= cls;
      old_r <= cur_r;
      had_r <= cur_known_r;
    end
    if (p_vld_r) begin
      out_state_id_r <= p_idx_r;
      out_total_r    <= NOW_W'(q_total);
      out_count_r    <= CNT_W'(e0_cnt);
      out_last_r     <= NOW_W'(e0_time);
      out_ok_r       <= src_r || cur_known_r;
      out_is_last_r  <= (p_idx_r == PS_LAST);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_state_id      = out_state_id_r;
  assign out_total_time_ms = out_total_r;
  assign out_entry_count   = out_count_r;
  assign out_last_entry_ms = out_last_r;
  assign out_report_ok     = out_ok_r;
  assign out_is_last       = out_is_last_r;

endmodule

>>> tb/display_state_residency_counter_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the display state residency counter
// drives samples and queries, predicts the per-state records and checks each one
// depends on dsrc_pkg and display_state_residency_counter
module display_state_residency_counter_test;
  import dsrc_pkg::*;

  // item kinds on in_mode
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // register indexes with no register behind them
  localparam logic [IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [CLK_W-1:0] THRESH_MAX = '1;
  localparam logic [NOW_W-1:0] NOW_MAX    = '1;

  typedef struct packed {
    logic               mode;
    logic [NOW_W-1:0]   now_ms;
    logic               blank_ok;
    logic [BLANK_W-1:0] blank_value;
    logic               clock_ok;
    logic [CLK_W-1:0]   clock_hz;
  } sample_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] state_id;
    logic [NOW_W-1:0] total_ms;
    logic [CNT_W-1:0] entries;
    logic [NOW_W-1:0] entered_ms;
    logic             report_ok;
    logic             is_last;
  } residency_rec_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic               in_mode        = MODE_SAMPLE;
  logic [NOW_W-1:0]   in_now_ms      = '0;
  logic               in_blank_ok    = 1'b0;
  logic [BLANK_W-1:0] in_blank_value = '0;
  logic               in_clock_ok    = 1'b0;
  logic [CLK_W-1:0]   in_clock_hz    = '0;
  logic               out_valid;
  logic [IDX_W-1:0]   out_state_id;
  logic [NOW_W-1:0]   out_total_time_ms;
  logic [CNT_W-1:0]   out_entry_count;
  logic [NOW_W-1:0]   out_last_entry_ms;
  logic               out_report_ok;
  logic               out_is_last;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index      = '0;
  logic [CLK_W-1:0]   cfg_data       = '0;

  // predictor copy of configuration and residency state
  logic               src_present     = 1'b1;
  logic [CLK_W-1:0]   clk_thresh      = '0;
  logic [BLANK_W-1:0] last_blank      = '0;
  logic               last_blank_seen = 1'b0;
  logic [IDX_W-1:0]   cur_ps          = PS_OFF;
  logic               cur_seen        = 1'b0;
  logic [NOW_W-1:0]   ps_total      [PWR_STATE_CNT] = '{default: '0};
  logic [CNT_W-1:0]   ps_entries    [PWR_STATE_CNT] = '{default: '0};
  logic [NOW_W-1:0]   ps_entered_at [PWR_STATE_CNT] = '{default: '0};

  sample_item_t   pending_items[$];
  residency_rec_t expected_recs[$];
  sample_item_t   in_flight;
  int             queued_cnt      = 0;
  int             accepted_cnt    = 0;
  int             mismatches      = 0;
  int unsigned    sender_idle_pct = 22;
  logic [NOW_W-1:0] now_base      = '0;

  display_state_residency_counter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_now_ms        (in_now_ms),
    .in_blank_ok      (in_blank_ok),
    .in_blank_value   (in_blank_value),
    .in_clock_ok      (in_clock_ok),
    .in_clock_hz      (in_clock_hz),
    .out_valid        (out_valid),
    .out_state_id     (out_state_id),
    .out_total_time_ms(out_total_time_ms),
    .out_entry_count  (out_entry_count),
    .out_last_entry_ms(out_last_entry_ms),
    .out_report_ok    (out_report_ok),
    .out_is_last      (out_is_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // residency predictor: updates state on a sample, queues three records on a query
  task automatic advance_residency(input sample_item_t it);
    logic [IDX_W-1:0] nxt_ps;
    logic             ok;
    residency_rec_t   rec;
    if (it.mode == MODE_QUERY) begin
      ok = src_present || cur_seen;
      for (int s = 0; s < PWR_STATE_CNT; s++) begin
        rec.state_id = IDX_W'(s);
        rec.total_ms = ps_total[s];
        // live time only counts for the state the display is in now
        if (cur_seen && cur_ps == IDX_W'(s))
          rec.total_ms = ps_total[s] + (it.now_ms - ps_entered_at[s]);
        rec.entries    = ps_entries[s];
        rec.entered_ms = ps_entered_at[s];
        rec.report_ok  = ok;
        rec.is_last    = (IDX_W'(s) == PS_LAST);
        expected_recs.push_back(rec);
      end
    end else if (src_present && it.blank_ok &&
                 !(last_blank_seen && it.blank_value == last_blank)) begin
      last_blank      = it.blank_value;
      last_blank_seen = 1'b1;
      if (it.blank_value != '0)
        nxt_ps = PS_OFF;
      else if (it.clock_ok && it.clock_hz > clk_thresh)
        nxt_ps = PS_90HZ;
      else
        nxt_ps = PS_60HZ;
      if (!(cur_seen && nxt_ps == cur_ps)) begin
        if (cur_seen)
          ps_total[cur_ps] = ps_total[cur_ps] + (it.now_ms - ps_entered_at[cur_ps]);
        cur_ps                = nxt_ps;
        cur_seen              = 1'b1;
        ps_entries[nxt_ps]    = ps_entries[nxt_ps] + 1'b1;
        ps_entered_at[nxt_ps] = it.now_ms;
      end
    end
  endtask

  // item driver: one transfer per edge with start high and busy low
  always @(posedge clk) begin : item_driver
    sample_item_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        advance_residency(in_flight);
        accepted_cnt++;
      end
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt            = pending_items.pop_front();
        in_flight      = nxt;
        start          <= 1'b1;
        in_mode        <= nxt.mode;
        in_now_ms      <= nxt.now_ms;
        in_blank_ok    <= nxt.blank_ok;
        in_blank_value <= nxt.blank_value;
        in_clock_ok    <= nxt.clock_ok;
        in_clock_hz    <= nxt.clock_hz;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // record monitor: each strobed record against the oldest expectation
  always @(posedge clk) begin : record_monitor
    residency_rec_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_recs.size() == 0) begin
        $display("%0t: unexpected record, state_id %0h total %0h count %0h",
                 $time, out_state_id, out_total_time_ms, out_entry_count);
        mismatches++;
      end else begin
        want = expected_recs.pop_front();
        check_field("state_id", want.state_id, out_state_id);
        check_field("total_time_ms", want.total_ms, out_total_time_ms);
        check_field("entry_count", want.entries, out_entry_count);
        check_field("last_entry_ms", want.entered_ms, out_last_entry_ms);
        check_field("report_ok", want.report_ok, out_report_ok);
        check_field("is_last", want.is_last, out_is_last);
      end
    end
  end

  // register write over the cfg channel; predictor copy follows the transfer
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CLK_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SOURCE_PRESENT)
      src_present = data[0];
    else if (idx == CFG_CLOCK_THRESH)
      clk_thresh = data;
  endtask

  task automatic queue_sample(input logic [NOW_W-1:0] now, input logic ok,
                              input logic [BLANK_W-1:0] blank, input logic cok,
                              input logic [CLK_W-1:0] hz);
    pending_items.push_back('{MODE_SAMPLE, now, ok, blank, cok, hz});
    queued_cnt++;
  endtask

  task automatic queue_query(input logic [NOW_W-1:0] now);
    pending_items.push_back('{MODE_QUERY, now, 1'b1, BLANK_W'(0), 1'b1, CLK_W'(0)});
    queued_cnt++;
  endtask

  // wait for every transfer and record, then let a state write-back settle
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_recs.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random traffic: mostly valid samples that move between states, some queries
  task automatic queue_random(input int n);
    sample_item_t it;
    for (int k = 0; k < n; k++) begin
      it.mode = ($urandom_range(3) == 0) ? MODE_QUERY : MODE_SAMPLE;
      if ($urandom_range(15) == 0)
        now_base = {16'($urandom), 32'($urandom)};
      else
        now_base = now_base + NOW_W'($urandom_range(2000));
      it.now_ms      = now_base;
      it.blank_ok    = ($urandom_range(9) != 0);
      it.blank_value = ($urandom_range(1) == 0) ? BLANK_W'(0)
                                                : BLANK_W'($urandom_range(255, 1));
      it.clock_ok    = ($urandom_range(6) != 0);
      case ($urandom_range(2))
        0:       it.clock_hz = clk_thresh + CLK_W'($urandom_range(2)) - 1'b1;
        1:       it.clock_hz = {4'($urandom), 32'($urandom)};
        default: it.clock_hz = CLK_W'($urandom_range(1000000));
      endcase
      pending_items.push_back(it);
      queued_cnt++;
    end
  endtask

  task automatic run_phase(input logic src, input logic [CLK_W-1:0] thr,
                           input int unsigned idle_pct, input int n);
    write_reg(CFG_SOURCE_PRESENT, CLK_W'(src));
    write_reg(CFG_CLOCK_THRESH, thr);
    sender_idle_pct = idle_pct;
    queue_random(n);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // source absent before any state entered: samples dropped, reports not ok
    write_reg(CFG_SOURCE_PRESENT, CLK_W'(0));
    queue_query(NOW_W'(1234));
    queue_sample(NOW_W'(1300), 1'b1, 8'd0, 1'b1, CLK_W'(5));
    queue_query(NOW_MAX);
    wait_drained();

    // spare indexes must not disturb anything
    write_reg(CFG_SOURCE_PRESENT, CLK_W'(1));
    write_reg(CFG_SPARE_A, THRESH_MAX);
    write_reg(CFG_SPARE_B, CLK_W'(0));
    queue_query(NOW_W'(10));
    queue_sample(NOW_W'(20), 1'b0, 8'd9, 1'b1, CLK_W'(7));       // failed blank read
    queue_sample(NOW_W'(100), 1'b1, 8'd0, 1'b1, CLK_W'(0));      // first sample, 60 Hz
    queue_sample(NOW_W'(150), 1'b1, 8'd0, 1'b1, THRESH_MAX);     // repeated blank value
    queue_sample(NOW_W'(200), 1'b1, 8'd3, 1'b1, CLK_W'(0));      // off
    queue_sample(NOW_W'(260), 1'b1, 8'd7, 1'b0, CLK_W'(0));      // still off
    queue_sample(NOW_W'(300), 1'b1, 8'd0, 1'b1, THRESH_MAX);     // 90 Hz
    queue_query(NOW_W'(450));
    queue_sample(NOW_W'(500), 1'b1, 8'd255, 1'b1, CLK_W'(0));    // off
    queue_sample(NOW_W'(620), 1'b1, 8'd0, 1'b0, THRESH_MAX);     // clock read failed
    queue_sample(48'hFFFF_FFFF_FF00, 1'b1, 8'd128, 1'b1, CLK_W'(0));
    queue_sample(NOW_W'(64), 1'b1, 8'd0, 1'b1, CLK_W'(1));       // time wraps
    queue_query(NOW_MAX);
    wait_drained();

    // top threshold: nothing can classify as 90 Hz
    write_reg(CFG_CLOCK_THRESH, THRESH_MAX);
    queue_sample(NOW_W'(1000), 1'b1, 8'd2, 1'b1, CLK_W'(0));
    queue_sample(NOW_W'(1100), 1'b1, 8'd0, 1'b1, THRESH_MAX);
    queue_query(NOW_W'(1200));
    wait_drained();

    // source lost after a state was entered: live time still reported
    write_reg(CFG_SOURCE_PRESENT, CLK_W'(0));
    queue_sample(NOW_W'(1300), 1'b1, 8'd5, 1'b1, CLK_W'(0));
    queue_query(NOW_W'(1400));
    wait_drained();

    now_base = NOW_W'(2000);
    run_phase(1'b1, {4'($urandom), 32'($urandom)}, 22, 55);
    run_phase(1'b1, CLK_W'(0), 22, 55);
    run_phase(1'b0, {4'($urandom), 32'($urandom)}, 64, 55);
    run_phase(1'b1, THRESH_MAX, 64, 55);
    run_phase(1'b1, {4'($urandom), 32'($urandom)}, 0, 55);
    run_phase(1'b1, CLK_W'($urandom_range(1000)), 0, 55);

    if (mismatches == 0)
      $display("display_state_residency_counter_test OK");
    else
      $display("display_state_residency_counter_test NOT OK");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("display_state_residency_counter_test NOT OK");
    $finish;
  end

endmodule

>>> files.f
rtl/dsrc_pkg.sv
rtl/display_state_residency_counter.sv
tb/display_state_residency_counter_test.sv
